/* sv/assert_macros.svh */
// Assertion macros for the RTL of the heater and fan band-step controller.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HFBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HFBS_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define HFBS_ASSERT(lbl, prop, msg)
`define HFBS_NEVER(lbl, expr, msg)
`endif
`endif

/* sv/hfbs_pkg.sv */
// Package of the heater and fan band-step controller: widths, constants, codes,
// the sequencer state type, the divider status type and the duty step function.
// Depends on nothing.
package hfbs_pkg;

	localparam int DUTY_W = 7;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
	localparam int CAP_W = 16;
	localparam int ADC_W = 12;
	localparam int TEMP_W = 10;
	localparam int SPEED_W = 16;
	localparam int CLK_W = 27;
	localparam int PPR_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 27;

	localparam int GAIN_W = 14;
	localparam int PROD_W = 26;
	localparam logic [PROD_W-1:0] GAIN_Q16 = 26'd16371;
	localparam logic [PROD_W-1:0] OFFSET_Q16 = 26'd20525875;

	localparam int NUM_W = 33;
	localparam int DEN_W = PPR_W + CAP_W;
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_CAPTURE = 2'd1,
		FUNC_TEMP = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_TARGET = 3'd0,
		REG_TEMP_BAND = 3'd1,
		REG_SPEED_TARGET = 3'd2,
		REG_SPEED_BAND = 3'd3,
		REG_CAPTURE_CLOCK = 3'd4,
		REG_PULSES_PER_REV = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TICK_FAN,
		ST_CAP_MUL,
		ST_DIV_WAIT,
		ST_TEMP_FIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// Moves a duty one band step toward the set point.
	function automatic logic [DUTY_W-1:0] step_duty(
		input logic [DUTY_W-1:0] duty,
		input logic [SPEED_W-1:0] value,
		input logic [SPEED_W-1:0] target,
		input logic [SPEED_W-1:0] band
	);
		logic [SPEED_W:0] top;
		logic [SPEED_W:0] down;
		logic [DUTY_W:0] up3;
		logic [DUTY_W-1:0] res;
		top = {1'b0, target} + {1'b0, band};
		down = {1'b0, target} - {1'b0, band};
		up3 = {1'b0, duty} + (DUTY_W+1)'(3);
		if (value == target) begin
			res = duty;
		end else if ({1'b0, value} >= top) begin
			res = (duty <= DUTY_W'(2)) ? '0 : duty - DUTY_W'(3);
		end else if (value > target) begin
			res = (duty == '0) ? '0 : duty - DUTY_W'(1);
		end else if ((band > target) || ({1'b0, value} > down)) begin
			res = (duty >= DUTY_MAX - DUTY_W'(2)) ? DUTY_MAX : duty + DUTY_W'(1);
		end else begin
			res = (up3 >= {1'b0, DUTY_MAX}) ? DUTY_MAX : up3[DUTY_W-1:0];
		end
		return res;
	endfunction

endpackage

/* sv/hfbs_div.sv */
// Restoring divider, one quotient bit per cycle, for the fan speed computation.
// Depends on hfbs_pkg.
module hfbs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hfbs_pkg::NUM_W-1:0]  num,
	input  logic [hfbs_pkg::DEN_W-1:0]  den,
	output hfbs_pkg::div_sts_t          sts,
	output logic [hfbs_pkg::NUM_W-1:0]  quo
);

	logic [hfbs_pkg::DEN_W-1:0] rem_q;
	logic [hfbs_pkg::NUM_W-1:0] quo_q;
	logic [hfbs_pkg::DEN_W-1:0] den_q;
	logic [hfbs_pkg::CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [hfbs_pkg::DEN_W:0] sh;
	logic [hfbs_pkg::DEN_W:0] diff;
	logic fits;

	assign sh = {rem_q, quo_q[hfbs_pkg::NUM_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign fits = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= hfbs_pkg::CNT_W'(hfbs_pkg::NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - hfbs_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[hfbs_pkg::DEN_W-1:0] : sh[hfbs_pkg::DEN_W-1:0];
			quo_q <= {quo_q[hfbs_pkg::NUM_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo = quo_q;

endmodule

/* sv/heater_fan_band_step_controller_unit.sv */
// Top level of the heater and fan band-step controller: sequencer, state,
// configuration registers and result register. Depends on hfbs_pkg, hfbs_div
// and assert_macros.svh.
//
// Each accepted beat gives one result beat. A control tick runs the execute,
// fan step and finish states, a temperature sample execute, temperature finish
// and finish, a first or zero-period second capture execute and finish, and any
// other second capture also multiply and divider wait, where the 33-step
// restoring divider forms the fan speed. The block takes one item at a time and
// is not ready while an item is in work; it is ready again once the result is
// loaded. A finished result waits in the output register, and the next item may
// be accepted while it waits. Configuration writes are always taken.
`include "assert_macros.svh"

module heater_fan_band_step_controller_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [hfbs_pkg::CAP_W-1:0]        capture_value,
	input  logic [hfbs_pkg::ADC_W-1:0]        adc_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hfbs_pkg::DUTY_W-1:0]       heater_duty,
	output logic [hfbs_pkg::DUTY_W-1:0]       fan_duty,
	output logic [hfbs_pkg::SPEED_W-1:0]      fan_speed,
	output logic [hfbs_pkg::TEMP_W-1:0]       temperature,
	output logic                              period_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hfbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hfbs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	hfbs_pkg::state_t state_q, state_nxt;

	logic [hfbs_pkg::TEMP_W-1:0] temp_target_q, temp_band_q;
	logic [hfbs_pkg::SPEED_W-1:0] speed_target_q, speed_band_q;
	logic [hfbs_pkg::CLK_W-1:0] capture_clock_q;
	logic [hfbs_pkg::PPR_W-1:0] ppr_q;

	logic armed_q;
	logic [hfbs_pkg::CAP_W-1:0] first_q;
	logic [hfbs_pkg::SPEED_W-1:0] speed_q;
	logic [hfbs_pkg::TEMP_W-1:0] temp_q;
	logic [hfbs_pkg::DUTY_W-1:0] heater_duty_q, fan_duty_q;
	logic perr_q;

	hfbs_pkg::func_t func_q;
	logic [hfbs_pkg::CAP_W-1:0] cap_q;
	logic [hfbs_pkg::ADC_W-1:0] adc_q;
	logic [hfbs_pkg::PROD_W-1:0] prod_q;
	logic [hfbs_pkg::CAP_W-1:0] period_q;

	logic out_valid_q;
	logic [hfbs_pkg::DUTY_W-1:0] out_heater_q, out_fan_q;
	logic [hfbs_pkg::SPEED_W-1:0] out_speed_q;
	logic [hfbs_pkg::TEMP_W-1:0] out_temp_q;
	logic out_perr_q;

	logic in_acc;
	logic out_load;
	logic div_start;
	hfbs_pkg::div_sts_t div_sts;
	logic [hfbs_pkg::NUM_W-1:0] div_quo;
	logic [hfbs_pkg::NUM_W-1:0] div_num;
	logic [hfbs_pkg::DEN_W-1:0] div_den;
	logic [hfbs_pkg::PPR_W-1:0] ppr_eff;

	logic [hfbs_pkg::DUTY_W-1:0] step_duty_in, step_duty_out;
	logic [hfbs_pkg::SPEED_W-1:0] step_value, step_target, step_band;

	logic [hfbs_pkg::CAP_W-1:0] period_w;
	logic [hfbs_pkg::CAP_W:0] wrap_sum;
	logic [hfbs_pkg::PROD_W-1:0] prod_w;
	logic [hfbs_pkg::PROD_W-1:0] temp_diff;

	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hfbs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = hfbs_pkg::ST_EXEC;
				end
			end
			hfbs_pkg::ST_EXEC: begin
				case (func_q)
					hfbs_pkg::FUNC_TICK: state_nxt = hfbs_pkg::ST_TICK_FAN;
					hfbs_pkg::FUNC_CAPTURE: begin
						if (armed_q && (period_w != '0)) begin
							state_nxt = hfbs_pkg::ST_CAP_MUL;
						end else begin
							state_nxt = hfbs_pkg::ST_FINISH;
						end
					end
					hfbs_pkg::FUNC_TEMP: state_nxt = hfbs_pkg::ST_TEMP_FIN;
					default: state_nxt = hfbs_pkg::ST_FINISH;
				endcase
			end
			hfbs_pkg::ST_TICK_FAN: state_nxt = hfbs_pkg::ST_FINISH;
			hfbs_pkg::ST_CAP_MUL: state_nxt = hfbs_pkg::ST_DIV_WAIT;
			hfbs_pkg::ST_DIV_WAIT: begin
				if (div_sts.done) begin
					state_nxt = hfbs_pkg::ST_FINISH;
				end
			end
			hfbs_pkg::ST_TEMP_FIN: state_nxt = hfbs_pkg::ST_FINISH;
			hfbs_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = hfbs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = hfbs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == hfbs_pkg::ST_IDLE);
		div_start = (state_q == hfbs_pkg::ST_CAP_MUL);
		out_load = (state_q == hfbs_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hfbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// The heater step runs in the execute cycle, the fan step in the next one.
	always_comb begin
		if (state_q == hfbs_pkg::ST_TICK_FAN) begin
			step_duty_in = fan_duty_q;
			step_value = speed_q;
			step_target = speed_target_q;
			step_band = speed_band_q;
		end else begin
			step_duty_in = heater_duty_q;
			step_value = hfbs_pkg::SPEED_W'(temp_q);
			step_target = hfbs_pkg::SPEED_W'(temp_target_q);
			step_band = hfbs_pkg::SPEED_W'(temp_band_q);
		end
		step_duty_out = hfbs_pkg::step_duty(step_duty_in, step_value, step_target, step_band);
	end

	always_comb begin
		wrap_sum = {1'b0, {hfbs_pkg::CAP_W{1'b1}}} - {1'b0, first_q} + {1'b0, cap_q};
		if (cap_q > first_q) begin
			period_w = cap_q - first_q;
		end else if (first_q > cap_q) begin
			period_w = wrap_sum[hfbs_pkg::CAP_W-1:0];
		end else begin
			period_w = '0;
		end
	end

	assign ppr_eff = (ppr_q == '0) ? hfbs_pkg::PPR_W'(1) : ppr_q;
	assign div_num = hfbs_pkg::NUM_W'(capture_clock_q) * hfbs_pkg::NUM_W'(60);
	assign div_den = hfbs_pkg::DEN_W'(ppr_eff) * hfbs_pkg::DEN_W'(period_q);

	assign prod_w = hfbs_pkg::PROD_W'(adc_q) * hfbs_pkg::GAIN_Q16;
	assign temp_diff = prod_q - hfbs_pkg::OFFSET_Q16;

	hfbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_target_q <= hfbs_pkg::TEMP_W'(60);
			temp_band_q <= hfbs_pkg::TEMP_W'(2);
			speed_target_q <= hfbs_pkg::SPEED_W'(2000);
			speed_band_q <= hfbs_pkg::SPEED_W'(100);
			capture_clock_q <= hfbs_pkg::CLK_W'(1000000);
			ppr_q <= hfbs_pkg::PPR_W'(9);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hfbs_pkg::REG_TEMP_TARGET: temp_target_q <= cfg_data[hfbs_pkg::TEMP_W-1:0];
				hfbs_pkg::REG_TEMP_BAND: temp_band_q <= cfg_data[hfbs_pkg::TEMP_W-1:0];
				hfbs_pkg::REG_SPEED_TARGET: speed_target_q <= cfg_data[hfbs_pkg::SPEED_W-1:0];
				hfbs_pkg::REG_SPEED_BAND: speed_band_q <= cfg_data[hfbs_pkg::SPEED_W-1:0];
				hfbs_pkg::REG_CAPTURE_CLOCK: capture_clock_q <= cfg_data[hfbs_pkg::CLK_W-1:0];
				hfbs_pkg::REG_PULSES_PER_REV: ppr_q <= cfg_data[hfbs_pkg::PPR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			first_q <= '0;
			speed_q <= '0;
			temp_q <= '0;
			heater_duty_q <= '0;
			fan_duty_q <= '0;
			perr_q <= 1'b0;
		end else begin
			case (state_q)
				hfbs_pkg::ST_IDLE: perr_q <= 1'b0;
				hfbs_pkg::ST_EXEC: begin
					if (func_q == hfbs_pkg::FUNC_TICK) begin
						heater_duty_q <= step_duty_out;
					end else if (func_q == hfbs_pkg::FUNC_CAPTURE) begin
						if (!armed_q) begin
							first_q <= cap_q;
							armed_q <= 1'b1;
						end else begin
							armed_q <= 1'b0;
							perr_q <= (period_w == '0);
						end
					end
				end
				hfbs_pkg::ST_TICK_FAN: fan_duty_q <= step_duty_out;
				hfbs_pkg::ST_DIV_WAIT: begin
					if (div_sts.done) begin
						if (|div_quo[hfbs_pkg::NUM_W-1:hfbs_pkg::SPEED_W]) begin
							speed_q <= '1;
						end else begin
							speed_q <= div_quo[hfbs_pkg::SPEED_W-1:0];
						end
					end
				end
				hfbs_pkg::ST_TEMP_FIN: begin
					if (prod_q < hfbs_pkg::OFFSET_Q16) begin
						temp_q <= '0;
					end else begin
						temp_q <= temp_diff[hfbs_pkg::PROD_W-1:16];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= hfbs_pkg::func_t'(func);
			cap_q <= capture_value;
			adc_q <= adc_sample;
		end
		if (state_q == hfbs_pkg::ST_EXEC) begin
			prod_q <= prod_w;
			period_q <= period_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_heater_q <= heater_duty_q;
			out_fan_q <= fan_duty_q;
			out_speed_q <= speed_q;
			out_temp_q <= temp_q;
			out_perr_q <= perr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign heater_duty = out_heater_q;
	assign fan_duty = out_fan_q;
	assign fan_speed = out_speed_q;
	assign temperature = out_temp_q;
	assign period_error = out_perr_q;

	`HFBS_ASSERT(a_one_item, in_acc |=> !in_ready, "second item accepted while one is in work")
	`HFBS_NEVER(a_div_state, div_sts.busy && (state_q != hfbs_pkg::ST_DIV_WAIT), "divider busy outside its wait state")
	`HFBS_NEVER(a_duty_range, (heater_duty_q > hfbs_pkg::DUTY_MAX) || (fan_duty_q > hfbs_pkg::DUTY_MAX), "duty above its maximum")
	`HFBS_ASSERT(a_perr_disarm, out_load && perr_q |-> !armed_q, "zero period reported while capture still armed")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the heater and fan band-step controller unit.
// A directed table and random phases run under several register settings, with
// an in-bench predictor of duties, speed and temperature. Depends on hfbs_pkg and heater_fan_band_step_controller_unit.
module tb;
	import hfbs_pkg::*;

	localparam int OPENING_ROWS = 23;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int HOLD_AT = 160;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam longint CAP_TOP = (longint'(1) << CAP_W) - 1;
	localparam longint TEMP_TOP = (longint'(1) << TEMP_W) - 1;
	localparam longint SPEED_TOP = (longint'(1) << SPEED_W) - 1;

	typedef struct packed {
		logic [DUTY_W-1:0] heater;
		logic [DUTY_W-1:0] fan;
		logic [SPEED_W-1:0] rpm;
		logic [TEMP_W-1:0] deg;
		logic perr;
	} status_t;

	typedef struct packed {
		func_t f;
		logic [CAP_W-1:0] cap;
		logic [ADC_W-1:0] adc;
		logic typed;
		status_t want;
	} row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = FUNC_NONE;
	logic [CAP_W-1:0] capture_value = '0;
	logic [ADC_W-1:0] adc_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DUTY_W-1:0] heater_duty;
	logic [DUTY_W-1:0] fan_duty;
	logic [SPEED_W-1:0] fan_speed;
	logic [TEMP_W-1:0] temperature;
	logic period_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	heater_fan_band_step_controller_unit dut (.*);

	// Register copies and block state as the predictor sees them.
	logic [TEMP_W-1:0] cfg_temp_set = 10'd60;
	logic [TEMP_W-1:0] cfg_temp_half = 10'd2;
	logic [SPEED_W-1:0] cfg_rpm_set = 16'd2000;
	logic [SPEED_W-1:0] cfg_rpm_half = 16'd100;
	logic [CLK_W-1:0] cfg_tick_hz = 27'd1000000;
	logic [PPR_W-1:0] cfg_ppr = 8'd9;
	logic tach_armed = 1'b0;
	logic [CAP_W-1:0] tach_first = '0;
	logic [SPEED_W-1:0] rpm_now = '0;
	logic [TEMP_W-1:0] deg_now = '0;
	logic [DUTY_W-1:0] heat_duty_now = '0;
	logic [DUTY_W-1:0] fan_duty_now = '0;

	status_t status_due[$];
	logic idle_on = 1'b1;
	int unsigned bad = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned zero_periods = 0;
	int unsigned regs_written = 0;
	int unsigned settings_used = 1;

	row_t opening[OPENING_ROWS] = '{
		'{FUNC_NONE, 16'h0000, 12'h000, 1'b1, '{7'd0, 7'd0, 16'd0, 10'd0, 1'b0}},
		'{FUNC_TEMP, 16'h0000, 12'h000, 1'b1, '{7'd0, 7'd0, 16'd0, 10'd0, 1'b0}},
		'{FUNC_CAPTURE, 16'h0000, 12'h000, 1'b1, '{7'd0, 7'd0, 16'd0, 10'd0, 1'b0}},
		'{FUNC_CAPTURE, 16'h0000, 12'h000, 1'b1, '{7'd0, 7'd0, 16'd0, 10'd0, 1'b1}},
		'{FUNC_TEMP, 16'h0000, 12'hFFF, 1'b1, '{7'd0, 7'd0, 16'd0, 10'd709, 1'b0}},
		'{FUNC_TICK, 16'h0000, 12'h000, 1'b0, '0},
		'{FUNC_TEMP, 16'h0000, 12'd1253, 1'b0, '0},
		'{FUNC_TEMP, 16'h0000, 12'd1258, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'hFFFF, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'h0000, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'h0000, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'hFFFF, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'd100, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'd101, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'hFFFF, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'h0001, 12'h000, 1'b0, '0},
		'{FUNC_CAPTURE, 16'h1000, 12'h000, 1'b0, '0},
		'{FUNC_NONE, 16'hABCD, 12'hABC, 1'b0, '0},
		'{FUNC_CAPTURE, 16'h1D05, 12'h000, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 12'h000, 1'b0, '0},
		'{FUNC_TEMP, 16'h0000, 12'd1494, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 12'h000, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One band step of a duty toward its set point.
	function automatic logic [DUTY_W-1:0] band_step(logic [DUTY_W-1:0] duty,
			longint value, longint target, longint band);
		longint top;
		longint down;
		longint up;
		top = target + band;
		down = target - band;
		up = longint'(duty) + 3;
		if (value == target)
			return duty;
		if (value >= top)
			return (duty <= 2) ? '0 : duty - DUTY_W'(3);
		if (value > target)
			return (duty == 0) ? '0 : duty - DUTY_W'(1);
		if (value > down)
			return (duty >= DUTY_MAX - 2) ? DUTY_MAX : duty + DUTY_W'(1);
		return (up >= longint'(DUTY_MAX)) ? DUTY_MAX : DUTY_W'(up);
	endfunction

	// Advances the predicted block state by one item and returns the status it shows.
	function automatic status_t take_item(func_t f, logic [CAP_W-1:0] cap,
			logic [ADC_W-1:0] adc);
		status_t s;
		longint span;
		longint ppr;
		longint q;
		s = '0;
		case (f)
			FUNC_TICK: begin
				heat_duty_now = band_step(heat_duty_now, deg_now, cfg_temp_set, cfg_temp_half);
				fan_duty_now = band_step(fan_duty_now, rpm_now, cfg_rpm_set, cfg_rpm_half);
			end
			FUNC_CAPTURE: begin
				if (!tach_armed) begin
					tach_first = cap;
					tach_armed = 1'b1;
				end else begin
					tach_armed = 1'b0;
					if (cap > tach_first)
						span = longint'(cap) - longint'(tach_first);
					else if (tach_first > cap)
						span = (CAP_TOP - longint'(tach_first)) + longint'(cap);
					else
						span = 0;
					if (span == 0) begin
						s.perr = 1'b1;
					end else begin
						ppr = (cfg_ppr == 0) ? 1 : longint'(cfg_ppr);
						q = (longint'(cfg_tick_hz) * 60) / (ppr * span);
						rpm_now = (q > SPEED_TOP) ? SPEED_W'(SPEED_TOP) : SPEED_W'(q);
					end
				end
			end
			FUNC_TEMP: begin
				q = longint'(adc) * longint'(GAIN_Q16) - longint'(OFFSET_Q16);
				if (q < 0)
					deg_now = '0;
				else
					deg_now = ((q >>> 16) > TEMP_TOP) ? TEMP_W'(TEMP_TOP) : TEMP_W'(q >>> 16);
			end
			default: ;
		endcase
		s.heater = heat_duty_now;
		s.fan = fan_duty_now;
		s.rpm = rpm_now;
		s.deg = deg_now;
		return s;
	endfunction

	task automatic offer_item(func_t f, logic [CAP_W-1:0] cap, logic [ADC_W-1:0] adc,
			logic typed, status_t want);
		int unsigned gap;
		status_t due;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		capture_value <= cap;
		adc_sample <= adc;
		do @(posedge clk); while (!in_ready);
		due = take_item(f, cap, adc);
		status_due.push_back(typed ? want : due);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEMP_TARGET: cfg_temp_set = data[TEMP_W-1:0];
			REG_TEMP_BAND: cfg_temp_half = data[TEMP_W-1:0];
			REG_SPEED_TARGET: cfg_rpm_set = data[SPEED_W-1:0];
			REG_SPEED_BAND: cfg_rpm_half = data[SPEED_W-1:0];
			REG_CAPTURE_CLOCK: cfg_tick_hz = data[CLK_W-1:0];
			REG_PULSES_PER_REV: cfg_ppr = data[PPR_W-1:0];
			default: ;
		endcase
		regs_written++;
	endtask

	task automatic program_settings(int unsigned t_set, int unsigned t_half,
			int unsigned r_set, int unsigned r_half, int unsigned hz, int unsigned ppr,
			logic with_spare);
		if (with_spare) begin
			write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
			write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
		end
		write_reg(REG_TEMP_TARGET, CFG_DATA_W'(t_set));
		write_reg(REG_TEMP_BAND, CFG_DATA_W'(t_half));
		write_reg(REG_SPEED_TARGET, CFG_DATA_W'(r_set));
		write_reg(REG_SPEED_BAND, CFG_DATA_W'(r_half));
		write_reg(REG_CAPTURE_CLOCK, CFG_DATA_W'(hz));
		write_reg(REG_PULSES_PER_REV, CFG_DATA_W'(ppr));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		int phase;
		int unsigned pick;
		int unsigned r_set;
		func_t f;
		logic [CAP_W-1:0] cap;
		logic [ADC_W-1:0] adc;
		longint span;
		longint ppr;
		longint near;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			offer_item(opening[i].f, opening[i].cap, opening[i].adc, opening[i].typed,
				opening[i].want);
		in_valid <= 1'b0;
		for (phase = 0; phase < PHASES; phase++) begin
			while (status_due.size() != 0) @(posedge clk);
			case (phase)
				0: program_settings(0, 0, 0, 0, 1, 1, 1'b1);
				1: program_settings(1023, 1023, 65535, 65535, 100000000, 255, 1'b0);
				2: program_settings(20, 300, 500, 4000, 1000000, 0, 1'b0);
				default: begin
					r_set = $urandom_range(0, 65535);
					program_settings($urandom_range(0, 720),
						$urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 60),
						r_set, $urandom_range(0, r_set / 4 + 1), $urandom_range(1, 100000000),
						$urandom_range(1, 255), 1'b0);
				end
			endcase
			idle_on = (phase % 3) != 2;
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				cap = CAP_W'($urandom());
				adc = ADC_W'($urandom());
				if (pick < 35) begin
					f = FUNC_TICK;
				end else if (pick < 70) begin
					f = FUNC_CAPTURE;
					if (tach_armed && $urandom_range(0, 4) != 0) begin
						ppr = (cfg_ppr == 0) ? 1 : longint'(cfg_ppr);
						if ($urandom_range(0, 2) == 0 && cfg_rpm_set != 0)
							span = (longint'(cfg_tick_hz) * 60) / (ppr * longint'(cfg_rpm_set))
								+ longint'($urandom_range(0, 8)) - 4;
						else
							span = longint'($urandom_range(0, 1 << $urandom_range(0, 16)));
						cap = CAP_W'(longint'(tach_first) + span);
					end
				end else if (pick < 95) begin
					f = FUNC_TEMP;
					if ($urandom_range(0, 9) >= 7) begin
						near = (longint'(cfg_temp_set) * 65536 + longint'(OFFSET_Q16))
							/ longint'(GAIN_Q16) + longint'($urandom_range(0, 24)) - 12;
						adc = (near < 0) ? '0 : (near > 4095) ? '1 : ADC_W'(near);
					end
				end else begin
					f = FUNC_NONE;
				end
				offer_item(f, cap, adc, 1'b0, '0);
			end
			in_valid <= 1'b0;
		end
		while (status_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("summary: %0d items (%0d from the directed table), %0d results checked, %0d zero periods",
			items_sent, OPENING_ROWS, results_seen, zero_periods);
		$display("summary: %0d register writes over %0d settings, output held for %0d cycles once",
			regs_written, settings_used, HOLD_CYCLES);
		if (bad == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin : results
		int unsigned stall;
		logic held;
		status_t want;
		status_t got;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 13) : 0;
			if (results_seen == HOLD_AT && !held) begin
				stall = HOLD_CYCLES;
				held = 1'b1;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{heater_duty, fan_duty, fan_speed, temperature, period_error};
			if (status_due.size() == 0) begin
				$error("result beat with nothing outstanding");
				bad++;
			end else begin
				want = status_due.pop_front();
				if (got.heater !== want.heater) begin
					$error("heater_duty: expected %0d, got %0d", want.heater, got.heater);
					bad++;
				end
				if (got.fan !== want.fan) begin
					$error("fan_duty: expected %0d, got %0d", want.fan, got.fan);
					bad++;
				end
				if (got.rpm !== want.rpm) begin
					$error("fan_speed: expected %0d, got %0d", want.rpm, got.rpm);
					bad++;
				end
				if (got.deg !== want.deg) begin
					$error("temperature: expected %0d, got %0d", want.deg, got.deg);
					bad++;
				end
				if (got.perr !== want.perr) begin
					$error("period_error: expected %0d, got %0d", want.perr, got.perr);
					bad++;
				end
				if (want.perr)
					zero_periods++;
			end
			results_seen++;
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: errors");
		$finish;
	end

endmodule
